### hw/rtl/hrfp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrfp_pkg
// Types, constants and character helpers for the response framing parser.
// ----------------------------------------------------------------------------
package hrfp_pkg;

	localparam int COUNT_BITS_DEFAULT = 24;
	localparam logic [23:0] LIMIT_RESET = 24'd8388608;

	typedef enum logic [3:0] {
		PH_STATUS = 4'd0,
		PH_HDR    = 4'd1,
		PH_LEN    = 4'd2,
		PH_CLOSE  = 4'd3,
		PH_CSIZE  = 4'd4,
		PH_CEXT   = 4'd5,
		PH_CDATA  = 4'd6,
		PH_CCR    = 4'd7,
		PH_CLF    = 4'd8,
		PH_TRAIL  = 4'd9,
		PH_DONE   = 4'd10,
		PH_BAD    = 4'd11
	} phase_t;

	typedef enum logic [1:0] {
		V_INCOMPLETE = 2'd0,
		V_COMPLETE   = 2'd1,
		V_CLOSE      = 2'd2,
		V_INVALID    = 2'd3
	} verdict_t;

	typedef enum logic [1:0] {
		VS_LEAD  = 2'd0,
		VS_TOKEN = 2'd1,
		VS_TRAIL = 2'd2,
		VS_BAD   = 2'd3
	} vscan_t;

	localparam logic [7:0] CR_BYTE = 8'd13;
	localparam logic [7:0] LF_BYTE = 8'd10;

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic logic [7:0] cl_char(input logic [4:0] p);
		logic [7:0] r;
		unique case (p)
			5'd0: r = "c";  5'd1: r = "o";  5'd2: r = "n";  5'd3: r = "t";
			5'd4: r = "e";  5'd5: r = "n";  5'd6: r = "t";  5'd7: r = "-";
			5'd8: r = "l";  5'd9: r = "e";  5'd10: r = "n"; 5'd11: r = "g";
			5'd12: r = "t"; 5'd13: r = "h";
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] te_char(input logic [4:0] p);
		logic [7:0] r;
		unique case (p)
			5'd0: r = "t";  5'd1: r = "r";  5'd2: r = "a";  5'd3: r = "n";
			5'd4: r = "s";  5'd5: r = "f";  5'd6: r = "e";  5'd7: r = "r";
			5'd8: r = "-";  5'd9: r = "e";  5'd10: r = "n"; 5'd11: r = "c";
			5'd12: r = "o"; 5'd13: r = "d"; 5'd14: r = "i"; 5'd15: r = "n";
			5'd16: r = "g";
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] ck_char(input logic [2:0] p);
		logic [7:0] r;
		unique case (p)
			3'd0: r = "c"; 3'd1: r = "h"; 3'd2: r = "u"; 3'd3: r = "n";
			3'd4: r = "k"; 3'd5: r = "e"; 3'd6: r = "d";
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	// Hex digit value; bit 4 set means not a hex digit.
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		if (c >= "0" && c <= "9") r = 5'(c - "0");
		else if (c >= "a" && c <= "f") r = 5'(c - "a" + 8'd10);
		else if (c >= "A" && c <= "F") r = 5'(c - "A" + 8'd10);
		else r = 5'd16;
		return r;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/hrfp_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrfp_engine
// Parse state and next-state logic: each accepted request updates all state.
// ----------------------------------------------------------------------------
module hrfp_engine import hrfp_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  step,
	input  wire logic                  command,
	input  wire logic [7:0]            data_byte,
	input  wire logic [COUNT_BITS-1:0] limit,
	output logic [7:0]                 body_byte,
	output logic                       body_valid,
	output logic [1:0]                 framing_status,
	output logic                       final_res
);

	localparam int CW = COUNT_BITS + 1;

	phase_t          phase_q, phase_d;
	verdict_t        verdict_q, verdict_d;
	vscan_t          vs_q, vs_d, vs_e;
	logic            cr_q, cr_d, colon_q, colon_d, lseen_q, lseen_d, cseen_q, cseen_d;
	logic [4:0]      npos_q, npos_d, npos_e;
	logic [1:0]      flags_q, flags_d, flags_e;
	logic [2:0]      vpos_q, vpos_d;
	logic [CW-1:0]   acc_q, acc_d, rem_q, rem_d, body_q, body_d, raw_q, raw_d;

	logic [CW-1:0]   lim, raw_inc;
	logic [CW+3:0]   dec_mul, hex_mul;
	logic [CW:0]     chunk_sum;
	logic            line_end_hit, empty_line, token_ok, emit_ok;
	logic            raw_over, line_ph, cr_line;
	logic [7:0]      lc, ch;
	logic [4:0]      hx;
	logic            do_ch;

	assign lim = CW'(limit);
	assign lc  = to_lower(ch);
	assign hx  = hex_value(ch);
	assign dec_mul = (CW+4)'(acc_q) * (CW+4)'(10) + (CW+4)'(ch - "0");
	assign hex_mul = {acc_q, hx[3:0]};
	assign chunk_sum = (CW+1)'(acc_q) + (CW+1)'(body_q);
	assign empty_line = (npos_q == 5'd0) && !colon_q;
	assign token_ok = (vs_q == VS_TOKEN) || (vs_q == VS_TRAIL);
	assign emit_ok = body_q < lim;

	// The raw byte count is checked before anything else sees the byte.
	assign raw_inc = (raw_q <= lim) ? raw_q + CW'(1) : raw_q;
	assign raw_over = (phase_q != PH_BAD) && (raw_inc > lim);
	assign line_ph = (phase_q == PH_STATUS) || (phase_q == PH_HDR) ||
		(phase_q == PH_CSIZE) || (phase_q == PH_CEXT) || (phase_q == PH_TRAIL);
	assign cr_line = !command && !raw_over && line_ph && cr_q && (data_byte != LF_BYTE);

	// A pending CR that does not close the line is an ordinary line byte, taken
	// before the new byte. It never matches a name, a digit or a value word.
	always_comb begin
		npos_e = npos_q; flags_e = flags_q; vs_e = vs_q;
		if (cr_line) begin
			if (phase_q == PH_HDR) begin
				if (!colon_q) begin
					flags_e = 2'b00;
					if (npos_q < 5'd31) npos_e = npos_q + 5'd1;
				end else if (flags_q != 2'b00) vs_e = VS_BAD;
			end else if (phase_q == PH_CSIZE) vs_e = VS_BAD;
			else if (phase_q == PH_TRAIL) begin
				if (npos_q < 5'd31) npos_e = npos_q + 5'd1;
			end
		end
	end

	always_comb begin
		phase_d = phase_q; verdict_d = verdict_q; vs_d = vs_e; cr_d = cr_q;
		colon_d = colon_q; lseen_d = lseen_q; cseen_d = cseen_q; npos_d = npos_e;
		flags_d = flags_e; vpos_d = vpos_q; acc_d = acc_q; rem_d = rem_q;
		body_d = body_q; raw_d = raw_q;
		body_byte = 8'd0; body_valid = 1'b0; final_res = 1'b0;
		line_end_hit = 1'b0; do_ch = 1'b0; ch = data_byte;

		if (command) begin
			final_res = 1'b1;
			phase_d = PH_STATUS; verdict_d = V_INCOMPLETE; vs_d = VS_LEAD; cr_d = 1'b0;
			colon_d = 1'b0; lseen_d = 1'b0; cseen_d = 1'b0; npos_d = 5'd0;
			flags_d = 2'b11; vpos_d = 3'd0; acc_d = '0; rem_d = '0;
			body_d = '0; raw_d = '0;
		end else begin
			if (phase_q != PH_BAD) raw_d = raw_inc;
			if (raw_over) begin
				phase_d = PH_BAD; verdict_d = V_INVALID;
			end else begin
				unique case (phase_q)
					PH_BAD: ;
					PH_DONE: begin phase_d = PH_BAD; verdict_d = V_INVALID; end
					PH_LEN, PH_CLOSE, PH_CDATA: begin
						if (!emit_ok) begin
							phase_d = PH_BAD; verdict_d = V_INVALID;
						end else begin
							body_d = body_q + CW'(1);
							body_byte = data_byte; body_valid = 1'b1;
							if (phase_q != PH_CLOSE) begin
								rem_d = rem_q - CW'(1);
								if (rem_q == CW'(1)) begin
									if (phase_q == PH_LEN) begin
										phase_d = PH_DONE; verdict_d = V_COMPLETE;
									end else phase_d = PH_CCR;
								end
							end
						end
					end
					PH_CCR: begin
						if (data_byte == CR_BYTE) phase_d = PH_CLF;
						else begin phase_d = PH_BAD; verdict_d = V_INVALID; end
					end
					PH_CLF: begin
						if (data_byte == LF_BYTE) begin
							phase_d = PH_CSIZE;
							npos_d = 5'd0; flags_d = 2'b11; vs_d = VS_LEAD;
							vpos_d = 3'd0; colon_d = 1'b0; acc_d = '0;
						end else begin phase_d = PH_BAD; verdict_d = V_INVALID; end
					end
					default: begin
						if (cr_q && data_byte == LF_BYTE) begin
							cr_d = 1'b0; line_end_hit = 1'b1;
						end else if (data_byte == CR_BYTE) cr_d = 1'b1;
						else begin
							cr_d = 1'b0; do_ch = 1'b1;
						end
					end
				endcase

				// The new byte works on the state left by any pending CR.
				if (do_ch) begin
					unique case (phase_q)
						PH_HDR: begin
							if (!colon_q) begin
								if (ch == ":") begin
									colon_d = 1'b1;
									flags_d[0] = flags_e[0] & (npos_e == 5'd14);
									flags_d[1] = flags_e[1] & (npos_e == 5'd17);
								end else begin
									if (!(npos_e < 5'd14 && lc == cl_char(npos_e)))
										flags_d[0] = 1'b0;
									if (!(npos_e < 5'd17 && lc == te_char(npos_e)))
										flags_d[1] = 1'b0;
									if (npos_e < 5'd31) npos_d = npos_e + 5'd1;
								end
							end else if (flags_e != 2'b00) begin
								logic ws, tok;
								ws = (ch == " ") || (ch == 8'd9);
								tok = 1'b0;
								unique case (vs_e)
									VS_LEAD:  if (!ws) begin vs_d = VS_TOKEN; tok = 1'b1; end
									VS_TOKEN: if (ws) vs_d = VS_TRAIL; else tok = 1'b1;
									VS_TRAIL: if (!ws) vs_d = VS_BAD;
									default: ;
								endcase
								if (tok) begin
									if (flags_e[0]) begin
										if (ch >= "0" && ch <= "9")
											acc_d = (dec_mul > (CW+4)'(lim)) ? lim + CW'(1)
												: CW'(dec_mul);
										else vs_d = VS_BAD;
									end else if (vpos_q < 3'd7 && lc == ck_char(vpos_q))
										vpos_d = vpos_q + 3'd1;
									else vs_d = VS_BAD;
								end
							end
						end
						PH_CSIZE: begin
							if (ch == ";") phase_d = PH_CEXT;
							else if (hx[4]) vs_d = VS_BAD;
							else begin
								acc_d = (hex_mul > (CW+4)'(lim)) ? lim + CW'(1) : CW'(hex_mul);
								if (vs_e == VS_LEAD) vs_d = VS_TOKEN;
							end
						end
						PH_TRAIL: begin
							if (ch == ":") colon_d = 1'b1;
							if (npos_e < 5'd31) npos_d = npos_e + 5'd1;
						end
						default: ;
					endcase
				end

				if (line_end_hit) begin
					npos_d = 5'd0; flags_d = 2'b11; vs_d = VS_LEAD;
					vpos_d = 3'd0; colon_d = 1'b0; acc_d = '0;
					unique case (phase_q)
						PH_STATUS: phase_d = PH_HDR;
						PH_HDR: begin
							if (empty_line) begin
								if (cseen_q) phase_d = PH_CSIZE;
								else if (lseen_q) begin
									if (rem_q == '0) begin
										phase_d = PH_DONE; verdict_d = V_COMPLETE;
									end else phase_d = PH_LEN;
								end else begin phase_d = PH_CLOSE; verdict_d = V_CLOSE; end
							end else if (!colon_q) begin
								phase_d = PH_BAD; verdict_d = V_INVALID;
							end else if (flags_q[0]) begin
								if (lseen_q || cseen_q || !token_ok || acc_q > lim) begin
									phase_d = PH_BAD; verdict_d = V_INVALID;
								end else begin lseen_d = 1'b1; rem_d = acc_q; end
							end else if (flags_q[1]) begin
								if (lseen_q || cseen_q || !token_ok || vpos_q != 3'd7) begin
									phase_d = PH_BAD; verdict_d = V_INVALID;
								end else cseen_d = 1'b1;
							end
						end
						PH_CSIZE, PH_CEXT: begin
							if (vs_q != VS_TOKEN) begin phase_d = PH_BAD; verdict_d = V_INVALID; end
							else if (acc_q == '0) phase_d = PH_TRAIL;
							else if (chunk_sum > (CW+1)'(lim)) begin
								phase_d = PH_BAD; verdict_d = V_INVALID;
							end else begin rem_d = acc_q; phase_d = PH_CDATA; end
						end
						PH_TRAIL: begin
							if (empty_line) begin phase_d = PH_DONE; verdict_d = V_COMPLETE; end
							else if (!colon_q) begin phase_d = PH_BAD; verdict_d = V_INVALID; end
						end
						default: ;
					endcase
				end
			end
		end
		framing_status = command ? verdict_q : verdict_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_STATUS; verdict_q <= V_INCOMPLETE; vs_q <= VS_LEAD;
			cr_q <= 1'b0; colon_q <= 1'b0; lseen_q <= 1'b0; cseen_q <= 1'b0;
			npos_q <= 5'd0; flags_q <= 2'b11; vpos_q <= 3'd0;
			acc_q <= '0; rem_q <= '0; body_q <= '0; raw_q <= '0;
		end else if (step) begin
			phase_q <= phase_d; verdict_q <= verdict_d; vs_q <= vs_d;
			cr_q <= cr_d; colon_q <= colon_d; lseen_q <= lseen_d; cseen_q <= cseen_d;
			npos_q <= npos_d; flags_q <= flags_d; vpos_q <= vpos_d;
			acc_q <= acc_d; rem_q <= rem_d; body_q <= body_d; raw_q <= raw_d;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/http_response_framing_parser_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// http_response_framing_parser_core
// HTTP/1.1 response framing parser with chunked body decoding.
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// in        input      in_valid/in_ready  command, data_byte
// out       output     out_valid/out_ready body_byte, body_valid, framing_status, final_res
// cfg       input      cfg_we             cfg_wdata
//
// One request per cycle unless out_ready stalls the output; results are registered.
// The rate is set by the parse state update in hrfp_engine.
// Input is taken whenever the result register is empty or being drained.
// Reset clears all parse state and loads the default response limit.
// ----------------------------------------------------------------------------
module http_response_framing_parser_core import hrfp_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        command,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       body_byte,
	output logic             body_valid,
	output logic [1:0]       framing_status,
	output logic             final_res,
	input  wire logic        cfg_we,
	input  wire logic [23:0] cfg_wdata
);

	logic [23:0]  limit_q;
	logic [7:0]   bb;
	logic         bv, fr;
	logic [1:0]   fs;
	logic         step;

	assign in_ready = !out_valid || out_ready;
	assign step = in_valid && in_ready;

	hrfp_engine #(.COUNT_BITS(COUNT_BITS)) u_engine (
		.clk(clk), .arst_n(arst_n), .step(step), .command(command),
		.data_byte(data_byte),
		.limit(COUNT_BITS'(limit_q)),
		.body_byte(bb), .body_valid(bv), .framing_status(fs), .final_res(fr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) limit_q <= LIMIT_RESET;
		else if (cfg_we) limit_q <= cfg_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (in_ready) out_valid <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (step) begin
			body_byte <= bb; body_valid <= bv; framing_status <= fs; final_res <= fr;
		end
	end

endmodule
`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives HTTP response byte streams and close requests into the framing
// parser, predicts every result with an internal parser model and checks
// each result field by field, under random sender and receiver idling.
// ----------------------------------------------------------------------------
module testbench;
	import hrfp_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        command = 1'b0;
	logic [7:0]  data_byte = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  body_byte;
	logic        body_valid;
	logic [1:0]  framing_status;
	logic        final_res;
	logic        cfg_we = 1'b0;
	logic [23:0] cfg_wdata = 24'd0;

	typedef struct packed {
		logic [7:0] body_byte;
		logic       body_valid;
		logic [1:0] framing_status;
		logic       final_res;
	} frame_res_t;

	typedef struct {
		logic       command;
		logic [7:0] data_byte;
		logic       fixed;
		frame_res_t want;
	} stim_row_t;

	http_response_framing_parser_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .data_byte(data_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.body_byte(body_byte), .body_valid(body_valid),
		.framing_status(framing_status), .final_res(final_res),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	initial begin
		#400ms;
		$display("tb: failure");
		$finish;
	end

	// Predictor state.
	logic [23:0] lim_reg;
	phase_t      ph;
	logic        crp;
	logic [4:0]  npos;
	logic [1:0]  nflags;
	logic [2:0]  vscan;
	logic [2:0]  vpos;
	logic        colon;
	logic        len_seen, chk_seen;
	logic [24:0] acc, remain, bcount, rcount;
	verdict_t    verd;

	frame_res_t expected_q[$];
	int errors = 0;
	int sender_idle = 9, receiver_idle = 85;

	function automatic logic [7:0] lc(input logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic logic is_ws(input logic [7:0] c);
		return c == " " || c == 8'd9;
	endfunction

	function automatic logic [4:0] hexval(input logic [7:0] c);
		if (c >= "0" && c <= "9") return 5'(c - "0");
		if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
		if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
		return 5'd16;
	endfunction

	task automatic clear_line();
		npos = 0; nflags = 2'b11; vscan = 0; vpos = 0; colon = 0; acc = 0;
	endtask

	task automatic clear_parse();
		ph = PH_STATUS; crp = 0; clear_line();
		len_seen = 0; chk_seen = 0; remain = 0; bcount = 0; rcount = 0;
		verd = V_INCOMPLETE;
	endtask

	task automatic mark_bad();
		ph = PH_BAD; verd = V_INVALID;
	endtask

	task automatic value_char(input logic [7:0] c);
		string ck;
		logic [63:0] t;
		ck = "chunked";
		if (nflags[0]) begin
			if (c >= "0" && c <= "9") begin
				t = 64'(acc) * 64'd10 + 64'(c - "0");
				if (t > 64'(lim_reg)) acc = {1'b0, lim_reg} + 25'd1;
				else acc = 25'(t);
			end else vscan = 3;
		end else if (nflags[1]) begin
			if (vpos < 7 && lc(c) == ck[vpos]) vpos++;
			else vscan = 3;
		end
	endtask

	task automatic header_char(input logic [7:0] c);
		string cl, te;
		cl = "content-length";
		te = "transfer-encoding";
		if (!colon) begin
			if (c == ":") begin
				colon = 1;
				if (npos != 14) nflags[0] = 0;
				if (npos != 17) nflags[1] = 0;
			end else begin
				if (!(npos < 14 && lc(c) == cl[npos])) nflags[0] = 0;
				if (!(npos < 17 && lc(c) == te[npos])) nflags[1] = 0;
				if (npos < 31) npos++;
			end
			return;
		end
		if (nflags == 0) return;
		case (vscan)
			0: if (!is_ws(c)) begin vscan = 1; value_char(c); end
			1: if (is_ws(c)) vscan = 2; else value_char(c);
			2: if (!is_ws(c)) vscan = 3;
			default: ;
		endcase
	endtask

	task automatic line_char(input logic [7:0] c);
		logic [4:0] h;
		logic [63:0] t;
		case (ph)
			PH_HDR: header_char(c);
			PH_CSIZE: begin
				if (c == ";") ph = PH_CEXT;
				else begin
					h = hexval(c);
					if (h[4]) vscan = 3;
					else begin
						t = 64'(acc) * 64'd16 + 64'(h[3:0]);
						if (t > 64'(lim_reg)) acc = {1'b0, lim_reg} + 25'd1;
						else acc = 25'(t);
						if (vscan == 0) vscan = 1;
					end
				end
			end
			PH_TRAIL: begin
				if (c == ":") colon = 1;
				if (npos < 31) npos++;
			end
			default: ;
		endcase
	endtask

	task automatic line_done();
		logic empty, tok;
		empty = (npos == 0) && !colon;
		tok = (vscan == 1 || vscan == 2);
		case (ph)
			PH_STATUS: ph = PH_HDR;
			PH_HDR: begin
				if (empty) begin
					if (chk_seen) ph = PH_CSIZE;
					else if (len_seen) begin
						if (remain == 0) begin ph = PH_DONE; verd = V_COMPLETE; end
						else ph = PH_LEN;
					end else begin ph = PH_CLOSE; verd = V_CLOSE; end
				end else if (!colon) mark_bad();
				else if (nflags[0]) begin
					if (len_seen || chk_seen || !tok || acc > {1'b0, lim_reg}) mark_bad();
					else begin len_seen = 1; remain = acc; end
				end else if (nflags[1]) begin
					if (len_seen || chk_seen || !tok || vpos != 7) mark_bad();
					else chk_seen = 1;
				end
			end
			PH_CSIZE, PH_CEXT: begin
				if (vscan != 1) mark_bad();
				else if (acc == 0) ph = PH_TRAIL;
				else if (26'(acc) + 26'(bcount) > 26'(lim_reg)) mark_bad();
				else begin remain = acc; ph = PH_CDATA; end
			end
			PH_TRAIL: begin
				if (empty) begin ph = PH_DONE; verd = V_COMPLETE; end
				else if (!colon) mark_bad();
			end
			default: ;
		endcase
		clear_line();
	endtask

	function automatic logic body_out(input logic [7:0] c, inout frame_res_t r);
		if (bcount >= {1'b0, lim_reg}) begin
			ph = PH_BAD; verd = V_INVALID;
			return 0;
		end
		bcount++;
		r.body_byte = c;
		r.body_valid = 1;
		return 1;
	endfunction

	task automatic predict_frame(input logic cmd, input logic [7:0] c, output frame_res_t r);
		r = '0;
		if (cmd) begin
			r.framing_status = verd;
			r.final_res = 1;
			clear_parse();
			return;
		end
		if (ph != PH_BAD) begin
			if (rcount <= {1'b0, lim_reg}) rcount++;
			if (rcount > {1'b0, lim_reg}) mark_bad();
		end
		case (ph)
			PH_BAD: ;
			PH_DONE: mark_bad();
			PH_LEN: if (body_out(c, r)) begin
				remain--;
				if (remain == 0) begin ph = PH_DONE; verd = V_COMPLETE; end
			end
			PH_CLOSE: void'(body_out(c, r));
			PH_CDATA: if (body_out(c, r)) begin
				remain--;
				if (remain == 0) ph = PH_CCR;
			end
			PH_CCR: if (c == CR_BYTE) ph = PH_CLF; else mark_bad();
			PH_CLF: if (c == LF_BYTE) begin ph = PH_CSIZE; clear_line(); end
				else mark_bad();
			default: begin
				if (crp) begin
					crp = 0;
					if (c == LF_BYTE) begin
						line_done();
						r.framing_status = verd;
						return;
					end
					line_char(CR_BYTE);
				end
				if (c == CR_BYTE) crp = 1;
				else line_char(c);
			end
		endcase
		r.framing_status = verd;
	endtask

	// Receiver side: checks each accepted result against the oldest expectation.
	always @(posedge clk) begin
		frame_res_t w;
		if (out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				$error("result with nothing expected");
				errors++;
			end else begin
				w = expected_q.pop_front();
				if (body_byte !== w.body_byte) begin
					$error("body_byte expected %0d actual %0d", w.body_byte, body_byte);
					errors++;
				end
				if (body_valid !== w.body_valid) begin
					$error("body_valid expected %0d actual %0d", w.body_valid, body_valid);
					errors++;
				end
				if (framing_status !== w.framing_status) begin
					$error("framing_status expected %0d actual %0d",
						w.framing_status, framing_status);
					errors++;
				end
				if (final_res !== w.final_res) begin
					$error("final_res expected %0d actual %0d", w.final_res, final_res);
					errors++;
				end
			end
		end
		out_ready <= ($urandom_range(99) >= receiver_idle);
	end

	// Sends one request, predicting it at acceptance. Valid stays high into the
	// next request unless the sender idles.
	task automatic send_req(input logic cmd, input logic [7:0] c, input logic fixed = 0,
			input frame_res_t want = '0);
		frame_res_t r;
		while ($urandom_range(99) < sender_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		command <= cmd;
		data_byte <= c;
		do @(posedge clk); while (!in_ready);
		predict_frame(cmd, c, r);
		if (fixed && r != want) begin
			$error("directed row disagrees with predictor");
			errors++;
		end
		expected_q.push_back(fixed ? want : r);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_req(0, s[i]);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input logic [23:0] v);
		drain();
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		lim_reg = v;
	endtask

	function automatic string rand_case(input string s);
		string o;
		o = s;
		for (int i = 0; i < o.len(); i++)
			if ($urandom_range(1) && o[i] >= "a" && o[i] <= "z") o[i] = o[i] - 32;
		return o;
	endfunction

	function automatic string ws();
		case ($urandom_range(3))
			0: return "";
			1: return " ";
			2: return "\t";
			default: return " \t ";
		endcase
	endfunction

	// One random response: mostly well formed, sometimes broken.
	task automatic random_response();
		int mode, n, k;
		bit broken;
		string hdr;
		mode = $urandom_range(2);
		broken = ($urandom_range(99) < 20);
		send_text("HTTP/1.1 200 OK\r\n");
		if ($urandom_range(1)) send_text({rand_case("x-extra"), ":", ws(), "v", "\r\n"});
		n = $urandom_range(12);
		if (mode == 0) begin
			hdr = $sformatf("%0d", broken ? n + $urandom_range(3) : n);
			send_text({rand_case("content-length"), ":", ws(), hdr, ws(), "\r\n"});
		end else if (mode == 1) begin
			send_text({rand_case("transfer-encoding"), ":", ws(),
				rand_case("chunked"), ws(), "\r\n"});
		end
		if (broken && $urandom_range(2) == 0)
			send_text(mode == 0 ? "Transfer-Encoding: chunked\r\n" : "nocolon\r\n");
		send_text("\r\n");
		if (mode == 1) begin
			k = $urandom_range(3);
			for (int c = 0; c < k; c++) begin
				n = $urandom_range(1, 10);
				send_text({$sformatf("%h", n[3:0]), $urandom_range(1) ? ";ext=1" : "", "\r\n"});
				for (int i = 0; i < n; i++) send_req(0, 8'($urandom));
				if (broken && $urandom_range(1)) send_req(0, "x");
				send_text("\r\n");
			end
			send_text("0\r\n");
			if ($urandom_range(1)) send_text("Trailer: t\r\n");
			send_text("\r\n");
		end else begin
			for (int i = 0; i < n; i++) send_req(0, 8'($urandom));
		end
		if (broken) send_req(0, 8'($urandom));
		send_req(1, 8'($urandom));
	endtask

	task automatic noise_burst();
		int n;
		n = $urandom_range(1, 20);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(3))
				0: send_req(0, CR_BYTE);
				1: send_req(0, LF_BYTE);
				default: send_req(0, 8'($urandom));
			endcase
		end
		send_req(1, 8'($urandom));
	endtask

	task automatic random_phase(input int items);
		int start;
		start = 0;
		while (start < items) begin
			if ($urandom_range(9) < 8) random_response();
			else noise_burst();
			start += 50;
		end
	endtask

	stim_row_t dir_rows[$];

	function automatic frame_res_t fr(input logic [7:0] b, input logic bv,
			input verdict_t st, input logic fin);
		frame_res_t r;
		r.body_byte = b; r.body_valid = bv; r.framing_status = st; r.final_res = fin;
		return r;
	endfunction

	task automatic add_row(input logic cmd, input logic [7:0] c, input logic fx,
			input frame_res_t w = '0);
		stim_row_t s;
		s.command = cmd; s.data_byte = c; s.fixed = fx; s.want = w;
		dir_rows.push_back(s);
	endtask

	initial begin
		string s;
		lim_reg = LIMIT_RESET;
		clear_parse();
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: close after reset, lone CR, close-delimited body with byte 0xFF.
		add_row(1, 8'hFF, 1, fr(0, 0, V_INCOMPLETE, 1));
		add_row(0, "H", 1, fr(0, 0, V_INCOMPLETE, 0));
		add_row(0, CR_BYTE, 0);
		add_row(0, "x", 0);
		add_row(0, CR_BYTE, 0);
		add_row(0, LF_BYTE, 0);
		add_row(0, CR_BYTE, 0);
		add_row(0, LF_BYTE, 1, fr(0, 0, V_CLOSE, 0));
		add_row(0, 8'hFF, 1, fr(8'hFF, 1, V_CLOSE, 0));
		add_row(0, 8'h00, 1, fr(8'h00, 1, V_CLOSE, 0));
		add_row(1, 8'h00, 1, fr(0, 0, V_CLOSE, 1));
		// Header without a colon is invalid at its line end.
		s = "S\r\nbad\r\n";
		for (int i = 0; i < s.len(); i++) add_row(0, s[i], 0);
		add_row(0, "z", 1, fr(0, 0, V_INVALID, 0));
		add_row(1, 0, 1, fr(0, 0, V_INVALID, 1));
		foreach (dir_rows[i])
			send_req(dir_rows[i].command, dir_rows[i].data_byte,
				dir_rows[i].fixed, dir_rows[i].want);
		// Zero content length completes at once; a further byte is invalid.
		send_text("S\r\nContent-Length: 0\r\n\r\nq");
		send_req(1, 0);
		send_text("S\r\nContent-Length: 99999999999\r\n\r\n");
		send_req(1, 0);

		// Pause until every result has come.
		drain();
		random_phase(200);
		sender_idle = 85; receiver_idle = 9;
		write_limit(24'd1);
		random_phase(60);
		write_limit(24'd30);
		random_phase(150);
		sender_idle = 0; receiver_idle = 0;
		write_limit(24'hFFFFFF);
		random_phase(200);

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end
endmodule

### http_response_framing_parser_core.f
hw/rtl/hrfp_pkg.sv
hw/rtl/hrfp_engine.sv
hw/rtl/http_response_framing_parser_core.sv
sim/testbench.sv
